@@ hdl/mexp_pkg.sv @@
package mexp_pkg;

  localparam int unsigned EXP_BITS_DEF = 32;
  localparam int unsigned MOD_BITS_DEF = 30;
  localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_MUL,
    ST_SQR,
    ST_FIN
  } state_e;

endpackage

@@ hdl/mexp_modmul.sv @@
module mexp_modmul #(
  parameter int unsigned MOD_BITS = mexp_pkg::MOD_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [MOD_BITS-1:0] x_i,
  input  logic [MOD_BITS-1:0] y_i,
  input  logic [MOD_BITS-1:0] m_i,
  output logic                done_o,
  output logic [MOD_BITS-1:0] res_o
);
  import mexp_pkg::*;

  localparam int unsigned W  = MOD_BITS + 2;
  localparam int unsigned CW = $clog2(MOD_BITS + 1);

  logic [CW-1:0]       cnt_q, cnt_d;
  logic                done_q, done_d;
  logic [W-1:0]        r_q, r_d;
  logic [MOD_BITS-1:0] x_q, x_d;
  logic [MOD_BITS-1:0] y_q, y_d;
  logic [W-1:0]        m_ext, t0, t1, t2;

  assign m_ext = {2'b00, m_i};

  // Interleaved multiply: r = 2r + y_bit*x, then bring back below m.
  always_comb begin
    t0 = {r_q[W-2:0], 1'b0} + (y_q[MOD_BITS-1] ? {2'b00, x_q} : '0);
    t1 = (t0 >= m_ext) ? t0 - m_ext : t0;
    t2 = (t1 >= m_ext) ? t1 - m_ext : t1;
  end

  always_comb begin
    cnt_d  = cnt_q;
    r_d    = r_q;
    x_d    = x_q;
    y_d    = y_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d = CW'(MOD_BITS);
      r_d   = '0;
      x_d   = x_i;
      y_d   = y_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      r_d    = t2;
      y_d    = {y_q[MOD_BITS-2:0], 1'b0};
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    x_q <= x_d;
    y_q <= y_d;
  end

  assign done_o = done_q;
  assign res_o  = r_q[MOD_BITS-1:0];

endmodule

@@ hdl/modular_exponentiation_top.sv @@
// Right-to-left square-and-multiply modular exponentiation on one shared modmul unit.
// Each transaction runs K = L + P modmuls (L = bit length of exponent, P = its set bits,
// K = 1 for a zero exponent); a zero modulus runs none, and an all-ones exponent is the
// worst case.
// One transaction in flight; the next is accepted the cycle after the result is registered.
// Reset (asynchronous, active low) idles the block and sets modulus to 1000000007.
module modular_exponentiation_top #(
  parameter int unsigned EXP_BITS = mexp_pkg::EXP_BITS_DEF,
  parameter int unsigned MOD_BITS = mexp_pkg::MOD_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [MOD_BITS-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [MOD_BITS-1:0] base_i,
  input  logic [EXP_BITS-1:0] exponent_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [MOD_BITS-1:0] power_o
);
  import mexp_pkg::*;

  state_e              state_q, state_d;
  logic [MOD_BITS-1:0] modulus_q;
  logic [MOD_BITS-1:0] acc_q, acc_d;
  logic [MOD_BITS-1:0] sq_q, sq_d;
  logic [EXP_BITS-1:0] e_q, e_d;
  logic [MOD_BITS-1:0] power_q, power_d;
  logic                out_valid_q, out_valid_d;
  logic [MOD_BITS-1:0] one_v;
  logic [EXP_BITS-1:0] e_shr;

  logic                mm_start, mm_done;
  logic [MOD_BITS-1:0] mm_x, mm_y, mm_res;

  mexp_modmul #(
    .MOD_BITS (MOD_BITS)
  ) u_modmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .x_i     (mm_x),
    .y_i     (mm_y),
    .m_i     (modulus_q),
    .done_o  (mm_done),
    .res_o   (mm_res)
  );

  // 1 mod m: zero when the modulus is one
  assign one_v = {{(MOD_BITS-1){1'b0}}, (modulus_q != MOD_BITS'(1))};
  assign e_shr = e_q >> 1;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    sq_d        = sq_q;
    e_d         = e_q;
    power_d     = power_q;
    out_valid_d = out_valid_q;
    mm_start    = 1'b0;
    mm_x        = acc_q;
    mm_y        = sq_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          e_d = exponent_i;
          if (modulus_q == '0) begin
            acc_d   = '0;
            state_d = ST_FIN;
          end else begin
            acc_d    = one_v;
            mm_start = 1'b1;
            mm_x     = one_v;
            mm_y     = base_i;
            state_d  = ST_RED;
          end
        end
      end
      ST_RED: begin
        if (mm_done) begin
          sq_d = mm_res;
          if (e_q == '0) begin
            state_d = ST_FIN;
          end else if (e_q[0]) begin
            mm_start = 1'b1;
            mm_x     = acc_q;
            mm_y     = mm_res;
            state_d  = ST_MUL;
          end else begin
            mm_start = 1'b1;
            mm_x     = mm_res;
            mm_y     = mm_res;
            state_d  = ST_SQR;
          end
        end
      end
      ST_MUL: begin
        if (mm_done) begin
          acc_d = mm_res;
          // skip the last square once no higher bits remain
          if (e_shr == '0) begin
            state_d = ST_FIN;
          end else begin
            mm_start = 1'b1;
            mm_x     = sq_q;
            mm_y     = sq_q;
            state_d  = ST_SQR;
          end
        end
      end
      ST_SQR: begin
        if (mm_done) begin
          sq_d = mm_res;
          e_d  = e_shr;
          if (e_shr == '0) begin
            state_d = ST_FIN;
          end else if (e_shr[0]) begin
            mm_start = 1'b1;
            mm_x     = acc_q;
            mm_y     = mm_res;
            state_d  = ST_MUL;
          end else begin
            mm_start = 1'b1;
            mm_x     = mm_res;
            mm_y     = mm_res;
            state_d  = ST_SQR;
          end
        end
      end
      ST_FIN: begin
        // hold until the result register is free
        if (!out_valid_q || out_ready_i) begin
          power_d     = acc_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      modulus_q   <= MODULUS_RESET[MOD_BITS-1:0];
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        modulus_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    sq_q    <= sq_d;
    e_q     <= e_d;
    power_q <= power_d;
  end

  assign out_valid_o = out_valid_q;
  assign power_o     = power_q;

endmodule

@@ test/tb_top.sv @@
module tb_top;
  import mexp_pkg::*;

  localparam int unsigned EB = EXP_BITS_DEF;
  localparam int unsigned MB = MOD_BITS_DEF;
  localparam int unsigned CYCLE_LIMIT = 10_000_000;
  localparam int unsigned DRAIN_CYCLES = 2100;
  localparam int unsigned HOLD_CYCLES = 4000;
  localparam int unsigned ITEMS_PER_PHASE = 166;
  localparam logic [MB-1:0] PRIME = MODULUS_RESET[MB-1:0];
  localparam logic [MB-1:0] TOP = {MB{1'b1}};

  typedef struct packed {
    logic [MB-1:0] modulus;
    logic [MB-1:0] base;
    logic [EB-1:0] exponent;
    logic          typed;
    logic [MB-1:0] power;
  } vec_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic [MB-1:0] cfg_wdata_i = '0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  logic [MB-1:0] base_i = '0;
  logic [EB-1:0] exponent_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  logic [MB-1:0] power_o;

  logic [MB-1:0] modulus_r = PRIME;
  logic [MB-1:0] power_q[$];
  vec_t          dir_vecs[0:23];
  int unsigned   errors = 0;
  int unsigned   n_results = 0;
  int unsigned   cycles = 0;
  bit            steady = 1'b0;

  modular_exponentiation_top #(
    .EXP_BITS(EB),
    .MOD_BITS(MB)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .base_i     (base_i),
    .exponent_i (exponent_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .power_o    (power_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, power_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Right-to-left square-and-multiply; a zero modulus yields zero.
  function automatic logic [MB-1:0] mod_pow(input logic [MB-1:0] m, input logic [MB-1:0] b,
                                            input logic [EB-1:0] e);
    logic [63:0] mm;
    logic [63:0] sq;
    logic [63:0] acc;
    int          i;
    if (m == '0) return '0;
    mm  = 64'(m);
    sq  = 64'(b) % mm;
    acc = 64'd1 % mm;
    for (i = 0; i < EB; i++) begin
      if (e[i]) acc = (acc * sq) % mm;
      sq = (sq * sq) % mm;
    end
    return acc[MB-1:0];
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_item(input logic [MB-1:0] b, input logic [EB-1:0] e,
                           input logic [MB-1:0] want);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    base_i     = b;
    exponent_i = e;
    do @(posedge clk_i); while (!in_ready_o);
    power_q = {power_q, want};
    @(negedge clk_i);
  endtask

  // Drop valid and let every pending result drain before touching the modulus.
  task automatic write_modulus(input logic [MB-1:0] m);
    in_valid_i = 1'b0;
    while (power_q.size() != 0) @(negedge clk_i);
    cfg_wdata_i = m;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    modulus_r   = m;
  endtask

  initial begin
    int unsigned gap;
    logic [MB-1:0] want;
    wait (rst_ni);
    forever begin
      gap = idle_len();
      if (n_results == 40 || n_results == 700) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_ready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      n_results++;
      if (power_q.size() == 0) begin
        $display("%0t: unexpected power transaction, got %0d", $time, power_o);
        errors++;
      end else begin
        want = power_q.pop_front();
        if (power_o !== want) begin
          $display("%0t: power mismatch, expected %0d, got %0d", $time, want, power_o);
          errors++;
        end
      end
      @(negedge clk_i);
    end
  end

  initial begin
    logic [MB-1:0] m;
    logic [MB-1:0] b;
    logic [EB-1:0] e;
    int unsigned   w;

    dir_vecs = '{
      '{PRIME, 30'd0, 32'd0, 1'b1, 30'd1},
      '{PRIME, 30'd5, 32'd0, 1'b1, 30'd1},
      '{PRIME, 30'd0, 32'd5, 1'b1, 30'd0},
      '{PRIME, 30'd2, 32'd1, 1'b1, 30'd2},
      '{PRIME, TOP, 32'd1, 1'b1, 30'd73741816},
      '{PRIME, PRIME, 32'd1, 1'b1, 30'd0},
      '{PRIME, PRIME - 30'd1, 32'd2, 1'b1, 30'd1},
      '{PRIME, PRIME - 30'd1, 32'hFFFF_FFFF, 1'b1, PRIME - 30'd1},
      '{PRIME, TOP, 32'hFFFF_FFFF, 1'b0, 30'd0},
      '{PRIME, 30'd3, 32'h8000_0000, 1'b0, 30'd0},
      // Fermat: a^(p-1) = 1 mod p
      '{PRIME, 30'd2, 32'd1000000006, 1'b1, 30'd1},
      '{PRIME, 30'd12345, 32'd1000000006, 1'b1, 30'd1},
      '{30'd0, 30'd7, 32'd3, 1'b1, 30'd0},
      '{30'd0, TOP, 32'd0, 1'b1, 30'd0},
      '{30'd1, 30'd5, 32'd0, 1'b1, 30'd0},
      '{30'd1, TOP, 32'hFFFF_FFFF, 1'b1, 30'd0},
      '{30'd2, 30'd3, 32'd0, 1'b1, 30'd1},
      '{30'd2, 30'd2, 32'd5, 1'b1, 30'd0},
      '{30'd2, TOP, 32'hFFFF_FFFF, 1'b1, 30'd1},
      '{TOP, TOP, 32'd7, 1'b1, 30'd0},
      '{TOP, TOP - 30'd1, 32'd2, 1'b1, 30'd1},
      '{TOP, TOP - 30'd1, 32'hFFFF_FFFF, 1'b1, TOP - 30'd1},
      '{TOP, 30'h2AAA_AAAA, 32'h5555_5555, 1'b0, 30'd0},
      '{TOP, 30'h1555_5555, 32'hAAAA_AAAA, 1'b0, 30'd0}
    };

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // First rows run on the reset modulus without any write.
    foreach (dir_vecs[i]) begin
      if (dir_vecs[i].modulus != modulus_r) write_modulus(dir_vecs[i].modulus);
      send_item(dir_vecs[i].base, dir_vecs[i].exponent,
                dir_vecs[i].typed ? dir_vecs[i].power
                                  : mod_pow(modulus_r, dir_vecs[i].base, dir_vecs[i].exponent));
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       m = TOP;
        1:       m = MB'($urandom_range(2, 1000));
        3:       m = MB'(1) << $urandom_range(1, MB - 1);
        5:       m = PRIME;
        6:       m = MB'($urandom) | (MB'(1) << (MB - 1));
        7:       m = MB'(2);
        default: m = MB'($urandom_range(2, 32'(TOP)));
      endcase
      write_modulus(m);
      steady = (ph == 2 || ph == 5);
      repeat (ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 4))
            0:       b = '0;
            1:       b = MB'(1);
            2:       b = m - MB'(1);
            3:       b = m;
            default: b = TOP;
          endcase
        end else begin
          b = MB'($urandom);
        end
        // Keep most exponents short; full-width ones are slow.
        if ($urandom_range(0, 15) == 0) begin
          e = $urandom;
        end else begin
          w = $urandom_range(0, 6);
          e = $urandom & ((EB'(1) << w) - EB'(1));
        end
        send_item(b, e, mod_pow(modulus_r, b, e));
      end
    end
    steady = 1'b0;
    in_valid_i = 1'b0;

    while (power_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
